FILE: hdl/wfha_pkg.sv
// Shared types and constants for the worst-fit heap allocator.
package wfha_pkg;

  localparam int unsigned HEADER_BYTES = 16;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_MEMORY  = 2'd1,
    ST_BAD_FREE   = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_BEST,
    RES_APPEND
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     scan_rd;
    logic     next_rd;
    logic     wr_best;
    logic     wr_split;
    logic     append;
    logic     wr_merged;
    logic     trim;
    logic     mv_up;
    logic     mv_down;
    logic     mv_step;
    logic     cnt_inc;
    logic     cnt_sub;
    logic     res_set;
    status_t  res_code;
    res_sel_t res_sel;
    logic     post;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_free;
    logic idx_end;
    logic rd_busy;
    logic found;
    logic hit_used;
    logic split_ok;
    logic has_next;
    logic next_free;
    logic over_limit;
    logic table_full;
    logic mv_done;
    logic trim_case;
    logic k_nz;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hdl/wfha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/wfha_datapath.sv
// Segment table, scan/compare logic, shift engine and result register.
module wfha_datapath
  import wfha_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDRESS_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output dp_stat_t                stat,
  input  logic                    in_req_type,
  input  logic [ADDRESS_BITS-1:0] in_req_size,
  input  logic [ADDRESS_BITS-1:0] in_req_address,
  input  logic                    cfg_wr_en,
  input  logic [ADDRESS_BITS:0]   cfg_wr_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ADDRESS_BITS-1:0] out_payload_address,
  output status_t                 out_status
);

  localparam int AW = ADDRESS_BITS;
  localparam int BW = ADDRESS_BITS + 1;
  localparam int EW = AW + BW + 1;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [1:0] {RK_SCAN, RK_NEXT, RK_MOVE} rd_kind_t;

  // Control state
  logic [CW-1:0] count_r, count_nxt;
  logic [BW-1:0] heap_end_r, heap_end_nxt;
  logic [BW-1:0] limit_r;
  logic          out_valid_r;
  logic          rdv_r;
  rd_kind_t      rd_kind_r;
  logic [CW-1:0] idx_r;
  logic          found_r;
  logic [CW-1:0] mv_left_r;
  logic          mv_up_r;

  // Payload registers
  logic          req_type_r;
  logic [AW-1:0] req_size_r, req_addr_r;
  logic [IW-1:0] rd_idx_r;
  logic [IW-1:0] tgt_idx_r;
  logic [AW-1:0] tgt_start_r;
  logic [BW-1:0] tgt_bytes_r;
  logic          tgt_used_r;
  logic [AW-1:0] prev_start_r;
  logic [BW-1:0] prev_bytes_r;
  logic          prev_used_r;
  logic [BW-1:0] nxt_bytes_r;
  logic          nxt_used_r;
  logic [IW-1:0] mv_src_r;
  logic [IW-1:0] mv_wa_r;
  logic [IW-1:0] mv_k_r;
  logic [AW-1:0] res_addr_r, out_addr_r;
  status_t       res_status_r, out_status_r;

  // RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic          rd_issue;
  rd_kind_t      rd_kind;

  logic [AW-1:0] rd_start;
  logic [BW-1:0] rd_bytes;
  logic          rd_used;

  logic [BW-1:0] need, rem, limit_eff;
  logic [BW:0]   append_end;
  logic [CW-1:0] tgt_c, f_idx, l_idx, k_cnt;
  logic          prev_free, next_free, has_next, mv_wr;
  logic [AW-1:0] m_start;
  logic [BW-1:0] m_bytes;

  assign rd_start = ram_rdata[AW-1:0];
  assign rd_bytes = ram_rdata[AW+BW-1:AW];
  assign rd_used  = ram_rdata[EW-1];

  assign need       = {1'b0, req_size_r} + BW'(HEADER_BYTES);
  assign rem        = tgt_bytes_r - need;
  assign limit_eff  = (limit_r < {1'b0, {AW{1'b1}}}) ? limit_r : {1'b0, {AW{1'b1}}};
  assign append_end = {1'b0, heap_end_r} + {1'b0, need};

  assign tgt_c     = CW'(tgt_idx_r);
  assign has_next  = (tgt_c + CW'(1)) < count_r;
  assign next_free = has_next && !nxt_used_r;
  assign prev_free = (tgt_idx_r != '0) && !prev_used_r;
  assign f_idx     = tgt_c - CW'(prev_free);
  assign l_idx     = tgt_c + CW'(next_free);
  assign k_cnt     = CW'(prev_free) + CW'(next_free);
  assign m_start   = prev_free ? prev_start_r : tgt_start_r;
  assign m_bytes   = (prev_free ? prev_bytes_r : '0) + tgt_bytes_r
                   + (next_free ? nxt_bytes_r : '0);

  assign mv_wr = rdv_r && (rd_kind_r == RK_MOVE);

  always_comb begin
    stat.is_free    = req_type_r;
    stat.idx_end    = idx_r == count_r;
    stat.rd_busy    = rdv_r;
    stat.found      = found_r;
    stat.hit_used   = tgt_used_r;
    stat.split_ok   = (rem > BW'(HEADER_BYTES)) && (count_r < CW'(MAX_SEGMENTS));
    stat.has_next   = has_next;
    stat.next_free  = next_free;
    stat.over_limit = append_end > {1'b0, limit_eff};
    stat.table_full = count_r >= CW'(MAX_SEGMENTS);
    stat.mv_done    = (mv_left_r == '0) && !rdv_r;
    stat.trim_case  = (l_idx + CW'(1)) == count_r;
    stat.k_nz       = k_cnt != '0;
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // Read port selection
  always_comb begin
    rd_issue  = 1'b0;
    rd_kind   = RK_SCAN;
    ram_raddr = idx_r[IW-1:0];
    priority if (cmd.scan_rd) begin
      rd_issue = 1'b1;
    end else if (cmd.next_rd) begin
      rd_issue  = 1'b1;
      rd_kind   = RK_NEXT;
      ram_raddr = tgt_idx_r + IW'(1);
    end else if (cmd.mv_step && mv_left_r != '0) begin
      rd_issue  = 1'b1;
      rd_kind   = RK_MOVE;
      ram_raddr = mv_src_r;
    end
  end

  // Write port selection
  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = tgt_idx_r;
    ram_wdata = ram_rdata;
    priority if (mv_wr) begin
      ram_waddr = mv_wa_r;
    end else if (cmd.wr_best) begin
      ram_wdata = {1'b1, (stat.split_ok ? need : tgt_bytes_r), tgt_start_r};
    end else if (cmd.wr_split) begin
      ram_waddr = tgt_idx_r + IW'(1);
      ram_wdata = {1'b0, rem + (next_free ? nxt_bytes_r : '0),
                   tgt_start_r + need[AW-1:0]};
    end else if (cmd.append) begin
      ram_waddr = count_r[IW-1:0];
      ram_wdata = {1'b1, need, heap_end_r[AW-1:0]};
    end else if (cmd.wr_merged) begin
      ram_waddr = f_idx[IW-1:0];
      ram_wdata = {1'b0, m_bytes, m_start};
    end else begin
      ram_we = 1'b0;
    end
  end

  wfha_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_SEGMENTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    count_nxt    = count_r;
    heap_end_nxt = heap_end_r;
    priority if (cmd.append) begin
      count_nxt    = count_r + CW'(1);
      heap_end_nxt = append_end[BW-1:0];
    end else if (cmd.trim) begin
      count_nxt    = f_idx;
      heap_end_nxt = {1'b0, m_start};
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_sub) begin
      count_nxt = count_r - k_cnt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      heap_end_r  <= '0;
      limit_r     <= BW'(1) << AW;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
      rd_kind_r   <= RK_SCAN;
      idx_r       <= '0;
      found_r     <= 1'b0;
      mv_left_r   <= '0;
      mv_up_r     <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      heap_end_r <= heap_end_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.post) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      rdv_r     <= rd_issue;
      rd_kind_r <= rd_kind;
      if (cmd.load) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else if (cmd.scan_rd) begin
        idx_r <= idx_r + CW'(1);
      end
      if (rdv_r && rd_kind_r == RK_SCAN) begin
        if (!req_type_r) begin
          if (!rd_used && rd_bytes >= need && rd_bytes > tgt_bytes_r) begin
            found_r <= 1'b1;
          end
        end else if (!found_r && ({1'b0, rd_start} + BW'(HEADER_BYTES))
                     == {1'b0, req_addr_r}) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.mv_up) begin
        mv_left_r <= count_r - (tgt_c + CW'(1));
        mv_up_r   <= 1'b1;
      end else if (cmd.mv_down) begin
        mv_left_r <= count_r - (l_idx + CW'(1));
        mv_up_r   <= 1'b0;
      end else if (cmd.mv_step && mv_left_r != '0) begin
        mv_left_r <= mv_left_r - CW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r  <= in_req_type;
      req_size_r  <= in_req_size;
      req_addr_r  <= in_req_address;
      tgt_bytes_r <= '0;
    end
    rd_idx_r <= ram_raddr;
    if (rdv_r && rd_kind_r == RK_SCAN) begin
      if (!req_type_r) begin
        if (!rd_used && rd_bytes >= need && rd_bytes > tgt_bytes_r) begin
          tgt_idx_r   <= rd_idx_r;
          tgt_start_r <= rd_start;
          tgt_bytes_r <= rd_bytes;
          tgt_used_r  <= rd_used;
        end
      end else if (!found_r) begin
        if (({1'b0, rd_start} + BW'(HEADER_BYTES)) == {1'b0, req_addr_r}) begin
          tgt_idx_r   <= rd_idx_r;
          tgt_start_r <= rd_start;
          tgt_bytes_r <= rd_bytes;
          tgt_used_r  <= rd_used;
        end else begin
          prev_start_r <= rd_start;
          prev_bytes_r <= rd_bytes;
          prev_used_r  <= rd_used;
        end
      end
    end
    if (rdv_r && rd_kind_r == RK_NEXT) begin
      nxt_bytes_r <= rd_bytes;
      nxt_used_r  <= rd_used;
    end
    if (cmd.mv_up) begin
      mv_src_r <= count_r[IW-1:0] - IW'(1);
    end else if (cmd.mv_down) begin
      mv_src_r <= l_idx[IW-1:0] + IW'(1);
      mv_k_r   <= k_cnt[IW-1:0];
    end else if (cmd.mv_step && mv_left_r != '0) begin
      mv_src_r <= mv_up_r ? mv_src_r - IW'(1) : mv_src_r + IW'(1);
      mv_wa_r  <= mv_up_r ? mv_src_r + IW'(1) : mv_src_r - mv_k_r;
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      unique case (cmd.res_sel)
        RES_BEST:   res_addr_r <= tgt_start_r + AW'(HEADER_BYTES);
        RES_APPEND: res_addr_r <= heap_end_r[AW-1:0] + AW'(HEADER_BYTES);
        default:    res_addr_r <= '0;
      endcase
    end
    if (cmd.post) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_payload_address = out_addr_r;
  assign out_status          = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond table depth");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mv_wr |-> !(cmd.wr_best || cmd.wr_split || cmd.append || cmd.wr_merged))
    else $error("shift write collides with table update");

  a_empty_heap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> heap_end_r == '0)
    else $error("empty table with non-zero heap end");

  a_post_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.post))
    else $error("result raised without post");

endmodule

FILE: hdl/wfha_ctrl.sv
// Request sequencer: scan, decide, shift and post the result.
module wfha_ctrl
  import wfha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_NEXT, S_SPLIT, S_FREE_FIN, S_MOVE, S_POST
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_code = ST_OK;
    cmd.res_sel  = RES_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = !stat.idx_end;
        if (stat.idx_end && !stat.rd_busy) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.is_free) begin
          if (stat.found) begin
            cmd.wr_best = 1'b1;
            if (!stat.split_ok) begin
              cmd.res_set = 1'b1;
              cmd.res_sel = RES_BEST;
              state_nxt   = S_POST;
            end else if (stat.has_next) begin
              cmd.next_rd = 1'b1;
              state_nxt   = S_NEXT;
            end else begin
              state_nxt = S_SPLIT;
            end
          end else begin
            cmd.res_set = 1'b1;
            state_nxt   = S_POST;
            priority if (stat.over_limit) begin
              cmd.res_code = ST_NO_MEMORY;
            end else if (stat.table_full) begin
              cmd.res_code = ST_TABLE_FULL;
            end else begin
              cmd.append  = 1'b1;
              cmd.res_sel = RES_APPEND;
            end
          end
        end else if (!stat.found || !stat.hit_used) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_BAD_FREE;
          state_nxt    = S_POST;
        end else if (stat.has_next) begin
          cmd.next_rd = 1'b1;
          state_nxt   = S_NEXT;
        end else begin
          state_nxt = S_FREE_FIN;
        end
      end
      S_NEXT: begin
        // neighbour data lands this cycle
        state_nxt = stat.is_free ? S_FREE_FIN : S_SPLIT;
      end
      S_SPLIT: begin
        if (stat.has_next && !stat.next_free) begin
          cmd.mv_up = 1'b1;
          state_nxt = S_MOVE;
        end else begin
          cmd.wr_split = 1'b1;
          cmd.cnt_inc  = !stat.next_free;
          cmd.res_set  = 1'b1;
          cmd.res_sel  = RES_BEST;
          state_nxt    = S_POST;
        end
      end
      S_FREE_FIN: begin
        if (stat.trim_case) begin
          cmd.trim    = 1'b1;
          cmd.res_set = 1'b1;
          state_nxt   = S_POST;
        end else begin
          cmd.wr_merged = 1'b1;
          if (stat.k_nz) begin
            cmd.mv_down = 1'b1;
            state_nxt   = S_MOVE;
          end else begin
            cmd.res_set = 1'b1;
            state_nxt   = S_POST;
          end
        end
      end
      S_MOVE: begin
        cmd.mv_step = 1'b1;
        if (stat.mv_done) begin
          cmd.mv_step = 1'b0;
          cmd.res_set = 1'b1;
          state_nxt   = S_POST;
          if (stat.is_free) begin
            cmd.cnt_sub = 1'b1;
          end else begin
            cmd.wr_split = 1'b1;
            cmd.cnt_inc  = 1'b1;
            cmd.res_sel  = RES_BEST;
          end
        end
      end
      S_POST: begin
        if (stat.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/worst_fit_heap_allocator_unit.sv
// Worst-fit heap allocator with coalescing: top level.
// Usage:
//   Input channel in_*: one request per handshake (in_valid high, in_stall low).
//   in_req_type 0 allocates in_req_size payload bytes, 1 frees in_req_address.
//   Output channel out_*: one result per request, in request order, carrying
//   the granted payload address (0 when none) and a status code.
//   cfg_wr_en/cfg_wr_data set the heap limit; write only while idle.
// Timing:
//   A request scans every live segment through the table RAM's single read
//   port, one per cycle. A split that must open an entry, or a free that
//   merges away entries, then shifts the entries above it, one per cycle,
//   through the same port; one request is worked on at a time.
//   The result sits in an output register, so the next request is taken
//   while the previous result waits under out_stall; a stalled result holds.
// Reset:
//   Synchronous, active low; clears the segment count, heap end and the
//   output valid, and restores the heap limit. No clearing pass is needed.
module worst_fit_heap_allocator_unit
  import wfha_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDRESS_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic [ADDRESS_BITS-1:0] in_req_size,
  input  logic [ADDRESS_BITS-1:0] in_req_address,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ADDRESS_BITS-1:0] out_payload_address,
  output logic [1:0]              out_status,
  input  logic                    cfg_wr_en,
  input  logic [ADDRESS_BITS:0]   cfg_wr_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  status_t   status;

  wfha_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  wfha_datapath #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_req_type        (in_req_type),
    .in_req_size        (in_req_size),
    .in_req_address     (in_req_address),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_address(out_payload_address),
    .out_status         (status)
  );

  assign out_status = status;

endmodule

FILE: test/worst_fit_heap_allocator_unit_tb.sv
// Self-checking testbench for the worst-fit heap allocator.
`timescale 1ns / 1ps
module worst_fit_heap_allocator_unit_tb
  import wfha_pkg::*;
;

  localparam int NSEG = 64;
  localparam int HDR = 16;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;
  localparam int QUIET = 300;

  typedef struct packed {
    logic        kind;
    logic [19:0] size;
    logic [19:0] addr;
  } request_t;

  typedef struct packed {
    logic [19:0] addr;
    status_t     status;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = 1'b0;
  logic [19:0] in_req_size = '0;
  logic [19:0] in_req_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [19:0] out_payload_address;
  logic [1:0] out_status;
  logic cfg_wr_en = 1'b0;
  logic [20:0] cfg_wr_data = '0;

  worst_fit_heap_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_req_size(in_req_size),
    .in_req_address(in_req_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_payload_address(out_payload_address), .out_status(out_status),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // predicted heap state
  logic [19:0] seg_start [NSEG];
  logic [20:0] seg_bytes [NSEG];
  logic        seg_used [NSEG];
  int          seg_count;
  logic [20:0] heap_top;
  logic [20:0] limit_reg;

  request_t pending_reqs [$];
  grant_t   expected_grants [$];
  logic [19:0] live_addrs [$];
  int errors = 0;
  int n_alloc = 0, n_free = 0, n_checked = 0;
  int st_seen [4] = '{0, 0, 0, 0};
  bit calm = 0;

  function automatic void remove_seg(int i);
    for (int j = i; j < seg_count - 1; j++) begin
      seg_start[j] = seg_start[j+1];
      seg_bytes[j] = seg_bytes[j+1];
      seg_used[j] = seg_used[j+1];
    end
    seg_count--;
  endfunction

  function automatic void insert_seg(int i);
    for (int j = seg_count; j > i; j--) begin
      seg_start[j] = seg_start[j-1];
      seg_bytes[j] = seg_bytes[j-1];
      seg_used[j] = seg_used[j-1];
    end
    seg_count++;
  endfunction

  function automatic void merge_with_next(int i);
    if (i + 1 < seg_count && !seg_used[i+1]) begin
      seg_bytes[i] += seg_bytes[i+1];
      remove_seg(i + 1);
    end
  endfunction

  function automatic grant_t heap_grant(request_t r);
    grant_t g;
    longint need, top, best_bytes;
    int best, i;
    bit found;
    g.addr = '0;
    g.status = ST_OK;
    if (r.kind == REQ_ALLOC) begin
      need = longint'(r.size) + HDR;
      best = 0; best_bytes = 0; found = 0;
      for (i = 0; i < seg_count; i++)
        if (!seg_used[i] && seg_bytes[i] >= need && seg_bytes[i] > best_bytes) begin
          best_bytes = seg_bytes[i]; best = i; found = 1;
        end
      if (found) begin
        seg_used[best] = 1'b1;
        if (best_bytes - need > HDR && seg_count < NSEG) begin
          insert_seg(best + 1);
          seg_start[best+1] = seg_start[best] + need[19:0];
          seg_bytes[best+1] = 21'(best_bytes - need);
          seg_used[best+1] = 1'b0;
          seg_bytes[best] = 21'(need);
          merge_with_next(best + 1);
        end
        g.addr = 20'(seg_start[best] + HDR);
      end else begin
        top = (limit_reg < 21'hFFFFF) ? limit_reg : 21'hFFFFF;
        if (longint'(heap_top) + need > top) g.status = ST_NO_MEMORY;
        else if (seg_count >= NSEG) g.status = ST_TABLE_FULL;
        else begin
          i = seg_count++;
          seg_start[i] = heap_top[19:0];
          seg_bytes[i] = 21'(need);
          seg_used[i] = 1'b1;
          heap_top = 21'(heap_top + need);
          g.addr = 20'(seg_start[i] + HDR);
        end
      end
    end else begin
      found = 0;
      for (i = 0; i < seg_count; i++)
        if (longint'(seg_start[i]) + HDR == longint'(r.addr)) begin
          found = 1; break;
        end
      if (!found || !seg_used[i]) g.status = ST_BAD_FREE;
      else begin
        seg_used[i] = 1'b0;
        merge_with_next(i);
        if (i > 0 && !seg_used[i-1]) begin
          seg_bytes[i-1] += seg_bytes[i];
          remove_seg(i);
          i--;
        end
        if (i + 1 == seg_count) begin
          heap_top = {1'b0, seg_start[i]};
          remove_seg(i);
        end
      end
    end
    return g;
  endfunction

  logic accepted_q = 1'b0;

  // driver: present requests from the queue, with random gaps
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || accepted_q) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_valid <= 1'b1;
          in_req_type <= pending_reqs[0].kind;
          in_req_size <= pending_reqs[0].size;
          in_req_address <= pending_reqs[0].addr;
          void'(pending_reqs.pop_front());
          if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 14);
        end else in_valid <= 1'b0;
      end
    end
  end

  // acceptance and prediction at the rising edge
  always @(posedge clk) begin
    accepted_q <= 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      request_t r;
      grant_t g;
      r = '{in_req_type, in_req_size, in_req_address};
      g = heap_grant(r);
      expected_grants.push_back(g);
      if (r.kind == REQ_ALLOC) n_alloc++; else n_free++;
      if (r.kind == REQ_ALLOC && g.status == ST_OK) live_addrs.push_back(g.addr);
      accepted_q <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      grant_t want;
      if (expected_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected result addr=%h status=%0d", $time,
                 out_payload_address, out_status);
      end else begin
        want = expected_grants.pop_front();
        n_checked++;
        st_seen[out_status]++;
        if (out_payload_address !== want.addr) begin
          errors++;
          $display("%0t: address mismatch expected %h actual %h", $time,
                   want.addr, out_payload_address);
        end
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   want.status, out_status);
        end
      end
    end
  end

  // receiver stalls in bursts
  int out_gap = 0;
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  function automatic request_t alloc_req(logic [19:0] sz);
    return '{REQ_ALLOC, sz, 20'($urandom)};
  endfunction

  function automatic request_t free_req(logic [19:0] a);
    return '{REQ_FREE, 20'($urandom), a};
  endfunction

  // release a random live allocation, or a bogus address now and then
  function automatic request_t random_free();
    int k;
    logic [19:0] a;
    if (live_addrs.size() == 0 || $urandom_range(0, 9) == 0) return free_req(20'($urandom));
    k = $urandom_range(0, live_addrs.size() - 1);
    a = live_addrs[k];
    live_addrs.delete(k);
    return free_req(a);
  endfunction

  function automatic logic [19:0] random_size();
    case ($urandom_range(0, 9))
      0: return 20'($urandom);
      1: return 20'($urandom_range(0, 16));
      2, 3: return 20'($urandom_range(0, 4096));
      default: return 20'($urandom_range(0, 512));
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_grants.size() > 0)
      @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic set_limit(logic [20:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v;
  endtask

  // random phase; frees are issued from the live list as it stands when queued
  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      while (pending_reqs.size() > 4) @(posedge clk);
      if ($urandom_range(0, 1) == 0) pending_reqs.push_back(alloc_req(random_size()));
      else pending_reqs.push_back(random_free());
    end
    wait_drained();
  endtask

  initial begin
    seg_count = 0;
    heap_top = '0;
    limit_reg = 21'h100000;
    for (int i = 0; i < NSEG; i++) seg_used[i] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, splits, merges, bad frees
    pending_reqs.push_back(alloc_req(20'd0));
    pending_reqs.push_back(alloc_req(20'd100));
    pending_reqs.push_back(alloc_req(20'hFFFF0));
    pending_reqs.push_back(alloc_req(20'd1000));
    pending_reqs.push_back(alloc_req(20'd1000));
    pending_reqs.push_back(free_req(20'd16));
    pending_reqs.push_back(free_req(20'd16));
    pending_reqs.push_back(free_req(20'hFFFFF));
    pending_reqs.push_back(free_req(20'd0));
    pending_reqs.push_back(free_req(20'd148));
    pending_reqs.push_back(alloc_req(20'd10));
    pending_reqs.push_back(alloc_req(20'd50));
    pending_reqs.push_back(free_req(20'd1164));
    pending_reqs.push_back(free_req(20'd32));
    pending_reqs.push_back(alloc_req(20'd500));
    pending_reqs.push_back(alloc_req(20'd500));
    wait_drained();
    live_addrs.delete();
    for (int i = 0; i < seg_count; i++)
      if (seg_used[i]) live_addrs.push_back(20'(seg_start[i] + HDR));

    // pause the sender until all results are in, then fill the table
    for (int i = 0; i < 70; i++) pending_reqs.push_back(alloc_req(20'($urandom_range(0, 40))));
    wait_drained();
    live_addrs.delete();
    for (int i = 0; i < seg_count; i++)
      if (seg_used[i]) live_addrs.push_back(20'(seg_start[i] + HDR));
    random_phase(200);

    set_limit(21'd0);
    random_phase(60);
    set_limit(21'h1FFFFF);
    random_phase(300);
    set_limit(21'd20000);
    random_phase(300);
    set_limit(21'($urandom_range(1000, 200000)));
    random_phase(250);
    set_limit(21'h100000);
    calm = 1;
    random_phase(250);

    $display("covered %0d allocates, %0d frees, %0d results checked", n_alloc, n_free,
             n_checked);
    $display("status counts ok/oom/badfree/full: %0d %0d %0d %0d", st_seen[0], st_seen[1],
             st_seen[2], st_seen[3]);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: sim.f
hdl/wfha_pkg.sv
hdl/wfha_ram.sv
hdl/wfha_datapath.sv
hdl/wfha_ctrl.sv
hdl/worst_fit_heap_allocator_unit.sv
test/worst_fit_heap_allocator_unit_tb.sv
